@@ rtl/shellsort_records_by_key_core_macros.svh @@
// Assertion macros for the record sorter.
// Included by the core; needs a clock and reset signal in the including scope.
`ifndef SHELLSORT_RECORDS_BY_KEY_CORE_MACROS_SVH
`define SHELLSORT_RECORDS_BY_KEY_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define SSRK_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define SSRK_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/ssrk_pkg.sv @@
// Shared types and constants of the rating record sorter.
// No dependencies; imported by shellsort_records_by_key_core.
package ssrk_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int ID_W         = 31;
   localparam int KEY_W        = 16;

   // Input item as it arrives on the request port
   typedef struct packed {
      logic [ID_W-1:0]  user_id;
      logic [ID_W-1:0]  movie_id;
      logic [KEY_W-1:0] rating_key;
      logic [ID_W-1:0]  stamp;
      logic             end_of_set;
   } req_type;

   // Result item on the response port
   typedef struct packed {
      logic [ID_W-1:0]  out_user_id;
      logic [ID_W-1:0]  out_movie_id;
      logic [KEY_W-1:0] out_rating_key;
      logic [ID_W-1:0]  out_stamp;
      logic             last_of_run;
   } rsp_type;

   // One stored record
   typedef struct packed {
      logic [ID_W-1:0]  user_id;
      logic [ID_W-1:0]  movie_id;
      logic [KEY_W-1:0] rating_key;
      logic [ID_W-1:0]  stamp;
   } rec_type;

endpackage

@@ rtl/shellsort_records_by_key_core.sv @@
// Rating record sorter: record store, Shellsort sequencer and output stream.
// Depends on ssrk_pkg and shellsort_records_by_key_core_macros.svh.
//
//   channel   ports                       flow
//   --------  --------------------------  ---------------------------------------
//   request   start, busy, req_item       item taken when start high, busy low
//   response  rsp_strobe, rsp_item        strobe marks each item, no back-pressure
//
// Loading stores items in arrival order until the store is full. The item with
// end_of_set starts the sort. Each pass first rebuilds its gap from 1 along
// 3h+1. Each record of a pass is then fetched, compared with its gapped neighbor
// and written; a shifted record moves the walk down one gap, and a place step
// writes the record when the walk reaches the bottom, all bound by the single
// read port of the record memory. Emission streams the n records through the
// registered read. Synchronous reset clears control only; no clearing pass.
// The receiver cannot stall, so busy depends on the sequencer alone.

`include "shellsort_records_by_key_core_macros.svh"

module shellsort_records_by_key_core #(
   parameter int CAPACITY = ssrk_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssrk_pkg::req_type req_item,
   output logic              rsp_strobe,
   output ssrk_pkg::rsp_type rsp_item
);
   import ssrk_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_GAP   = 3'd1;
   localparam logic [2:0] ST_HOLD  = 3'd2;
   localparam logic [2:0] ST_CMP   = 3'd3;
   localparam logic [2:0] ST_PLACE = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] gap_ff, gap_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   rec_type       hold_ff, hold_in;
   logic          emit_vld_ff, emit_vld_in;
   logic          emit_last_ff, emit_last_in;

   // record memory, one write and one registered read per cycle
   rec_type       mem [CAPACITY];
   rec_type       rdata_ff;
   logic          mem_we;
   logic [CW-1:0] mem_wa;
   rec_type       mem_wd;
   logic          mem_re;
   logic [CW-1:0] mem_ra;

   logic [CW-1:0] n_new;
   logic [CW+1:0] gap_next;
   logic [CW-1:0] i_next;
   logic [CW-1:0] j_next;
   rec_type       req_rec;

   assign req_rec = '{user_id:    req_item.user_id,
                      movie_id:   req_item.movie_id,
                      rating_key: req_item.rating_key,
                      stamp:      req_item.stamp};

   assign n_new    = (count_ff < CAP_C) ? count_ff + ONE_C : count_ff;
   assign gap_next = {2'b00, gap_ff} + {1'b0, gap_ff, 1'b0} + (CW+2)'(1);
   assign i_next   = i_ff + ONE_C;
   assign j_next   = j_ff - gap_ff;

   // sequencer: load, derive gap, gapped insertion, emit
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      gap_in       = gap_ff;
      lim_in       = lim_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      hold_in      = hold_ff;
      emit_vld_in  = 1'b0;
      emit_last_in = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = count_ff;
      mem_wd       = req_rec;
      mem_re       = 1'b0;
      mem_ra       = i_ff;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (start) begin
               // store unless full
               mem_we   = (count_ff < CAP_C);
               count_in = n_new;
               if (req_item.end_of_set) begin
                  count_in = '0;
                  n_in     = n_new;
                  k_in     = '0;
                  gap_in   = ONE_C;
                  lim_in   = n_new - ONE_C;
                  state_in = (n_new <= ONE_C) ? ST_EMIT : ST_GAP;
               end
            end
         end
         ST_GAP: begin
            // grow gap along 3h+1 while it stays below the bound
            if (gap_next < {2'b00, lim_ff}) begin
               gap_in = gap_next[CW-1:0];
            end else begin
               i_in     = gap_ff;
               mem_re   = 1'b1;
               mem_ra   = gap_ff;
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            // take record i, fetch its gapped neighbor
            hold_in  = rdata_ff;
            j_in     = i_ff;
            mem_re   = 1'b1;
            mem_ra   = i_ff - gap_ff;
            state_in = ST_CMP;
         end
         ST_CMP, ST_PLACE: begin
            mem_we = 1'b1;
            mem_wa = j_ff;
            mem_wd = hold_ff;
            if (state_ff == ST_CMP && hold_ff.rating_key < rdata_ff.rating_key) begin
               // shift neighbor up, keep walking down
               mem_wd = rdata_ff;
               j_in   = j_next;
               if (j_next >= gap_ff) begin
                  mem_re = 1'b1;
                  mem_ra = j_next - gap_ff;
               end else begin
                  state_in = ST_PLACE;
               end
            end else if (i_next < n_ff) begin
               // advance to next record of this pass
               i_in     = i_next;
               mem_re   = 1'b1;
               mem_ra   = i_next;
               state_in = ST_HOLD;
            end else if (gap_ff == ONE_C) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end else begin
               // next pass uses the previous gap of the sequence
               lim_in   = gap_ff;
               gap_in   = ONE_C;
               state_in = ST_GAP;
            end
         end
         ST_EMIT: begin
            mem_re       = 1'b1;
            mem_ra       = k_ff;
            emit_vld_in  = 1'b1;
            emit_last_in = (k_ff + ONE_C == n_ff);
            k_in         = k_ff + ONE_C;
            if (k_ff + ONE_C == n_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         emit_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         emit_vld_ff <= emit_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      gap_ff       <= gap_in;
      lim_ff       <= lim_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      hold_ff      <= hold_in;
      emit_last_ff <= emit_last_in;
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa[AW-1:0]] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_ra[AW-1:0]];
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = emit_vld_ff;
   assign rsp_item   = '{out_user_id:    rdata_ff.user_id,
                         out_movie_id:   rdata_ff.movie_id,
                         out_rating_key: rdata_ff.rating_key,
                         out_stamp:      rdata_ff.stamp,
                         last_of_run:    emit_last_ff};

   `SSRK_ASSERT_NXT(a_emit_strobe, state_ff == ST_EMIT, rsp_strobe,
      "emit cycle not followed by a response strobe")
   `SSRK_ASSERT_NOW(a_count_cap, 1'b1, count_ff <= CAP_C,
      "record count beyond capacity")
   `SSRK_ASSERT_NOW(a_gap_range, state_ff == ST_HOLD, gap_ff != '0 && gap_ff < n_ff,
      "gap out of range during insertion")
   `SSRK_ASSERT_NOW(a_last_clears, rsp_strobe && rsp_item.last_of_run,
      count_ff == '0 && state_ff == ST_IDLE,
      "last item leaves store not empty")

endmodule
